// ===== rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, constants and helpers for the UTF-8 validator with escape.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    // Byte class boundaries
    localparam logic [7:0] ASCII_LIMIT    = 8'h80;  // first non-ASCII byte
    localparam logic [7:0] CONT_FIRST     = 8'h80;  // continuation range low
    localparam logic [7:0] CONT_LAST      = 8'hBF;  // continuation range high
    localparam logic [7:0] LEAD2_FIRST    = 8'hC2;
    localparam logic [7:0] LEAD3_FIRST    = 8'hE0;
    localparam logic [7:0] LEAD4_FIRST    = 8'hF0;
    localparam logic [7:0] LEAD4_LAST     = 8'hF4;  // F5 and up are invalid
    localparam logic [7:0] ESC_LEAD       = 8'hDC;
    localparam logic [7:0] ESC_TRAIL_BASE = 8'h80;
    localparam logic [7:0] LOW7_MASK      = 8'h7F;

    // Sequence lengths held in the pending-length register
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // Depth of the command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // One emit command: up to four bytes, index of the final byte, escape flag
    typedef struct packed {
        logic [3:0][7:0] seq_bytes;
        logic [1:0]      last_idx;
        logic            esc;
    } cmd_t;

    // Escape pair DC, 80 | (lead & 7F)
    function automatic cmd_t make_escape(input logic [7:0] lead);
        cmd_t c;
        c              = '0;
        c.seq_bytes[0] = ESC_LEAD;
        c.seq_bytes[1] = ESC_TRAIL_BASE | (lead & LOW7_MASK);
        c.last_idx     = 2'd1;
        c.esc          = 1'b1;
        return c;
    endfunction

endpackage

// ===== rtl/utf8v_front.sv =====
// ----------------------------------------------------------------------------
// utf8v_front
// Accepts raw bytes, tracks the pending sequence and issues emit commands.
// ----------------------------------------------------------------------------
module utf8v_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    output logic             in_ready,
    input  logic             q_full,
    output logic             q_push,
    output utf8v_pkg::cmd_t  q_cmd
);

    logic [2:0] exp_len_reg, exp_len_next;
    logic [1:0] bytes_coll_reg, bytes_coll_next;
    logic [7:0] held_reg [3];

    logic       accept;
    logic       held_we;
    logic [1:0] held_idx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the byte against the pending state
    always_comb begin
        exp_len_next    = exp_len_reg;
        bytes_coll_next = bytes_coll_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        held_we         = 1'b0;
        held_idx        = 2'd0;
        if (accept) begin
            if (in_end) begin
                // flush a pending sequence as an escape pair
                if (exp_len_reg != utf8v_pkg::SEQ_NONE) begin
                    q_push          = 1'b1;
                    q_cmd           = utf8v_pkg::make_escape(held_reg[0]);
                    exp_len_next    = utf8v_pkg::SEQ_NONE;
                    bytes_coll_next = 2'd0;
                end
            end else if (exp_len_reg == utf8v_pkg::SEQ_NONE) begin
                if (in_byte < utf8v_pkg::ASCII_LIMIT) begin
                    q_push             = 1'b1;
                    q_cmd.seq_bytes[0] = in_byte;
                    q_cmd.last_idx     = 2'd0;
                end else if (in_byte inside {[utf8v_pkg::LEAD2_FIRST:
                                              utf8v_pkg::LEAD4_LAST]}) begin
                    held_we         = 1'b1;
                    held_idx        = 2'd0;
                    bytes_coll_next = 2'd1;
                    if (in_byte < utf8v_pkg::LEAD3_FIRST) begin
                        exp_len_next = utf8v_pkg::SEQ_LEN2;
                    end else if (in_byte < utf8v_pkg::LEAD4_FIRST) begin
                        exp_len_next = utf8v_pkg::SEQ_LEN3;
                    end else begin
                        exp_len_next = utf8v_pkg::SEQ_LEN4;
                    end
                end else begin
                    // bad lead byte
                    q_push = 1'b1;
                    q_cmd  = utf8v_pkg::make_escape(in_byte);
                end
            end else if (!(in_byte inside {[utf8v_pkg::CONT_FIRST:
                                             utf8v_pkg::CONT_LAST]})) begin
                // bad continuation: drop it, escape the held lead
                q_push          = 1'b1;
                q_cmd           = utf8v_pkg::make_escape(held_reg[0]);
                exp_len_next    = utf8v_pkg::SEQ_NONE;
                bytes_coll_next = 2'd0;
            end else if ({1'b0, bytes_coll_reg} + 3'd1 >= exp_len_reg) begin
                // sequence complete: held bytes then this one
                q_push          = 1'b1;
                q_cmd.seq_bytes = {4{in_byte}};
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < bytes_coll_reg) begin
                        q_cmd.seq_bytes[k] = held_reg[2'(k)];
                    end
                end
                q_cmd.last_idx  = bytes_coll_reg;
                exp_len_next    = utf8v_pkg::SEQ_NONE;
                bytes_coll_next = 2'd0;
            end else begin
                held_we         = 1'b1;
                held_idx        = (bytes_coll_reg == 2'd3) ? 2'd0 : bytes_coll_reg;
                bytes_coll_next = bytes_coll_reg + 2'd1;
            end
        end
    end

    // Pending-sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_len_reg    <= utf8v_pkg::SEQ_NONE;
            bytes_coll_reg <= 2'd0;
        end else begin
            exp_len_reg    <= exp_len_next;
            bytes_coll_reg <= bytes_coll_next;
        end
    end

    // Held bytes, no reset
    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_reg[held_idx] <= in_byte;
        end
    end

endmodule

// ===== rtl/utf8v_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8v_fifo
// Short command queue decoupling the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module utf8v_fifo #(
    parameter int DEPTH = utf8v_pkg::CMD_FIFO_DEPTH  // 2 or more
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  utf8v_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output utf8v_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8v_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/utf8v_back.sv =====
// ----------------------------------------------------------------------------
// utf8v_back
// Walks each queued command and emits its bytes one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module utf8v_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  utf8v_pkg::cmd_t  q_cmd,
    output logic             q_pop,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_esc,
    output logic             out_last,
    input  logic             out_ready
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       esc_reg;
    logic       last_reg;
    logic       load;
    logic       is_final;

    assign load     = !q_empty && (!valid_reg || out_ready);
    assign is_final = (idx_reg == q_cmd.last_idx);
    assign q_pop    = load && is_final;

    // Byte index and output valid
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_final ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= q_cmd.seq_bytes[idx_reg];
            esc_reg  <= q_cmd.esc;
            last_reg <= is_final;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_esc   = esc_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/utf8_validate_surrogate_escape.sv =====
// ----------------------------------------------------------------------------
// utf8_validate_surrogate_escape
// UTF-8 framing check; bad framing is replaced by a DC escape pair, second byte 80 | (lead & 7F).
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser     | tlast
//  s_      | in  | [7:0] in_byte  | -         | end_of_input
//  m_      | out | [7:0] out_byte | is_escape | last_of_char
//
//  The front takes one byte per cycle while the command queue has room.
//  The back emits one result byte per cycle while m_tready is high; a character
//  gives its n bytes, an escape pair two; m_tvalid follows the queue and output register.
//  Reset (aresetn low, synchronous) drops pending state and queued bytes.
//  m_tready low holds the output register; s_tready falls once the queue fills.
// ----------------------------------------------------------------------------
module utf8_validate_surrogate_escape #(
    parameter int FIFO_DEPTH = utf8v_pkg::CMD_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] is_escape
    output logic       m_tlast    // last_of_char
);

    logic            q_push, q_pop, q_full, q_empty;
    utf8v_pkg::cmd_t push_cmd, head_cmd;

    utf8v_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    utf8v_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    utf8v_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_esc   (m_tuser),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

endmodule
